[rtl/spd_pkg.sv]
// ---------------------------------------------------------------------------
// spd_pkg: shared types and constants of the scan packet deframer
// Beat layouts, header offsets, packet types and verdict codes.
// ---------------------------------------------------------------------------
package spd_pkg;

   // byte offset counter width and header length
   localparam int OFFSET_BITS  = 16;
   localparam int HEADER_BYTES = 60;

   // result queue depth
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   // last byte of each little-endian header field
   localparam int OFS_TYPE   = 3;
   localparam int OFS_SCAN   = 11;
   localparam int OFS_PACKET = 13;
   localparam int OFS_STATUS = 33;
   localparam int OFS_PPS    = 39;
   localparam int OFS_COUNT  = 41;
   localparam int OFS_ANGLE  = 47;
   localparam int OFS_STEP   = 51;

   // packet types
   localparam logic [15:0] TYPE_A = 16'd65;
   localparam logic [15:0] TYPE_B = 16'd66;

   // sample sizes in bytes
   localparam logic [2:0] SIZE_A = 3'd4;
   localparam logic [2:0] SIZE_B = 3'd6;

   // result kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // verdict codes
   localparam logic [1:0] V_OK   = 2'd0;
   localparam logic [1:0] V_DONE = 2'd1;
   localparam logic [1:0] V_ERR  = 2'd2;
   localparam logic [1:0] V_SCAN = 2'd3;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        packet_end;
      logic [31:0] packet_time;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [31:0]        distance;
      logic [15:0]        amplitude;
      logic signed [31:0] angle;
      logic [31:0]        sample_time;
      logic [1:0]         verdict;
      logic [15:0]        points_collected;
      logic               last;
   } rsp_type;

   // results produced by one byte, first in order in r0
   typedef struct packed {
      logic [1:0] num;
      rsp_type    r0;
      rsp_type    r1;
   } push_type;

endpackage

[rtl/spd_fifo.sv]
// ---------------------------------------------------------------------------
// spd_fifo: result queue
// Shift queue taking up to two beats per cycle and giving one while the result
// channel is not stalled; the head entry drives the result channel directly.
// ---------------------------------------------------------------------------
module spd_fifo
   import spd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   rsp_type                  q_ff  [FIFO_DEPTH];
   rsp_type                  q_in  [FIFO_DEPTH];
   rsp_type                  q_sh  [FIFO_DEPTH];
   logic [FIFO_CNT_BITS-1:0] cnt_ff;
   logic [FIFO_CNT_BITS-1:0] cnt_in;
   logic [FIFO_CNT_BITS-1:0] base;
   logic                     pop;

   // space for the two results a byte can cause
   assign room      = cnt_ff <= FIFO_CNT_BITS'(FIFO_DEPTH - 2);
   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = q_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   assign base      = cnt_ff - FIFO_CNT_BITS'(pop);

   // shift on pop, then write new beats behind the survivors
   always_comb begin
      for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
         q_sh[i] = pop ? q_ff[i + 1] : q_ff[i];
      end
      q_sh[FIFO_DEPTH - 1] = q_ff[FIFO_DEPTH - 1];
      for (int i = 0; i < FIFO_DEPTH; i++) begin
         q_in[i] = q_sh[i];
         if (push.num != 2'd0 && base == FIFO_CNT_BITS'(i)) begin
            q_in[i] = push.r0;
         end
         if (push.num == 2'd2 && base + FIFO_CNT_BITS'(1) == FIFO_CNT_BITS'(i)) begin
            q_in[i] = push.r1;
         end
      end
      cnt_in = base + FIFO_CNT_BITS'(push.num);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < FIFO_DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

[rtl/spd_core.sv]
// ---------------------------------------------------------------------------
// spd_core: byte register, header decode and sample assembly
// Holds one registered byte, decodes it against the packet state and
// hands up to two result beats to the queue in the same cycle.
// ---------------------------------------------------------------------------
module spd_core
   import spd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   input  logic     room,
   output push_type push
);

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    fire;

   // packet state
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [31:0]            hs_ff, hs_in;
   logic [15:0]            kind_ff, kind_in;
   logic [15:0]            pnum_ff, pnum_in;
   logic [15:0]            snum_ff, snum_in;
   logic [15:0]            expect_ff, expect_in;
   logic [15:0]            scan_id_ff, scan_id_in;
   logic                   stat_zero_ff, stat_zero_in;
   logic [15:0]            samples_ff, samples_in;
   logic [15:0]            pps_ff, pps_in;
   logic [31:0]            step_ff, step_in;
   logic [31:0]            run_ff, run_in;
   logic [47:0]            sbytes_ff, sbytes_in;
   logic [2:0]             pos_ff, pos_in;
   logic [15:0]            emitted_ff, emitted_in;
   logic [15:0]            pc_ff, pc_in;
   logic [1:0]             accept_ff, accept_in;
   logic [31:0]            time_ff, time_in;

   // decode helpers
   logic [OFFSET_BITS-1:0] o;
   logic [7:0]             b;
   logic                   first, hdr_ok, decide, type_ok, is_b, take, done, complete;
   logic [47:0]            sb_cur, sb_new;
   logic [2:0]             pos_cur, pos_new;
   logic [15:0]            emit_cur;
   logic [32:0]            sum;
   logic [31:0]            ang_sat;
   logic [1:0]             v;
   rsp_type                samp, stat;

   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_comb begin
      o       = offset_ff;
      b       = in_item_ff.data_byte;
      first   = o == '0;
      hdr_ok  = o != OFFSET_MAX;

      // new packet: latch time and clear the per-packet state
      time_in    = first ? in_item_ff.packet_time : time_ff;
      accept_in  = first ? V_ERR : accept_ff;
      sb_cur     = first ? '0 : sbytes_ff;
      pos_cur    = first ? '0 : pos_ff;
      emit_cur   = first ? '0 : emitted_ff;

      // header capture
      hs_in        = {b, hs_ff[31:8]};
      kind_in      = kind_ff;
      snum_in      = snum_ff;
      pnum_in      = pnum_ff;
      stat_zero_in = stat_zero_ff;
      pps_in       = pps_ff;
      samples_in   = samples_ff;
      run_in       = run_ff;
      step_in      = step_ff;
      if (hdr_ok) begin
         if (o == OFFSET_BITS'(OFS_TYPE))   kind_in      = hs_in[31:16];
         if (o == OFFSET_BITS'(OFS_SCAN))   snum_in      = hs_in[31:16];
         if (o == OFFSET_BITS'(OFS_PACKET)) pnum_in      = hs_in[31:16];
         if (o == OFFSET_BITS'(OFS_STATUS)) stat_zero_in = hs_in == '0;
         if (o == OFFSET_BITS'(OFS_PPS))    pps_in       = hs_in[31:16];
         if (o == OFFSET_BITS'(OFS_COUNT))  samples_in   = hs_in[31:16];
         if (o == OFFSET_BITS'(OFS_ANGLE))  run_in       = hs_in;
         if (o == OFFSET_BITS'(OFS_STEP))   step_in      = hs_in;
      end
      type_ok = kind_in == TYPE_A || kind_in == TYPE_B;
      is_b    = kind_in == TYPE_B;

      // packet sequence check at the last header byte
      decide     = hdr_ok && o == OFFSET_BITS'(HEADER_BYTES - 1);
      expect_in  = expect_ff;
      scan_id_in = scan_id_ff;
      pc_in      = pc_ff;
      if (decide) begin
         accept_in = V_ERR;
         if (pnum_in == 16'd1) begin
            expect_in  = 16'd1;
            scan_id_in = snum_in;
            pc_in      = '0;
            accept_in  = V_OK;
         end else if (expect_ff != 16'hFFFF && expect_ff + 16'd1 == pnum_in) begin
            if (scan_id_ff != snum_in) begin
               accept_in = V_SCAN;
            end else begin
               expect_in = pnum_in;
               accept_in = V_OK;
            end
         end
         if (accept_in == V_OK && stat_zero_in && !type_ok) begin
            accept_in = V_ERR;
         end
      end

      // sample assembly, one byte lane per beat
      take   = o >= OFFSET_BITS'(HEADER_BYTES) && accept_in == V_OK && stat_zero_in &&
               type_ok && emit_cur < samples_in;
      sb_new = sb_cur;
      case (pos_cur)
         3'd0:    sb_new[7:0]   = b;
         3'd1:    sb_new[15:8]  = b;
         3'd2:    sb_new[23:16] = b;
         3'd3:    sb_new[31:24] = b;
         3'd4:    sb_new[39:32] = b;
         3'd5:    sb_new[47:40] = b;
         default: sb_new = sb_cur;
      endcase
      pos_new = pos_cur + 3'd1;
      done    = take && (pos_new >= (is_b ? SIZE_B : SIZE_A));

      // saturating angle step
      sum = {run_in[31], run_in} + {step_in[31], step_in};
      if (sum[32] != sum[31]) begin
         ang_sat = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         ang_sat = sum[31:0];
      end

      samp                  = '0;
      samp.kind             = KIND_SAMPLE;
      samp.distance         = sb_new[31:0];
      samp.amplitude        = is_b ? sb_new[47:32] : 16'd0;
      samp.angle            = run_in;
      samp.sample_time      = time_in;
      samp.verdict          = V_OK;
      samp.last             = !in_item_ff.packet_end;

      sbytes_in  = sb_cur;
      pos_in     = pos_cur;
      emitted_in = emit_cur;
      if (take) begin
         sbytes_in = sb_new;
         pos_in    = pos_new;
      end
      if (done) begin
         run_in     = ang_sat;
         emitted_in = emit_cur + 16'd1;
         if (pc_in != 16'hFFFF) pc_in = pc_in + 16'd1;
         sbytes_in  = '0;
         pos_in     = '0;
      end
      samp.points_collected = pc_in;

      // end-of-packet status
      complete = o >= OFFSET_BITS'(HEADER_BYTES) || decide;
      v = V_ERR;
      if (complete) begin
         if (pps_in == '0)         v = V_ERR;
         else if (pps_in == pc_in) v = V_DONE;
         else                      v = accept_in;
      end
      stat                  = '0;
      stat.kind             = KIND_STATUS;
      stat.sample_time      = time_in;
      stat.verdict          = v;
      stat.points_collected = pc_in;
      stat.last             = 1'b1;

      // queue push
      push = '0;
      if (fire) begin
         if (done) begin
            push.r0  = samp;
            push.r1  = stat;
            push.num = in_item_ff.packet_end ? 2'd2 : 2'd1;
         end else if (in_item_ff.packet_end) begin
            push.r0  = stat;
            push.num = 2'd1;
         end
      end

      // offset advance
      if (in_item_ff.packet_end) offset_in = '0;
      else if (hdr_ok)           offset_in = o + OFFSET_BITS'(1);
      else                       offset_in = o;
   end

   // input register
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff <= req_data;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // packet state
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         hs_ff        <= '0;
         kind_ff      <= '0;
         pnum_ff      <= '0;
         snum_ff      <= '0;
         expect_ff    <= '0;
         scan_id_ff   <= '0;
         stat_zero_ff <= 1'b1;
         samples_ff   <= '0;
         pps_ff       <= '0;
         step_ff      <= '0;
         run_ff       <= '0;
         sbytes_ff    <= '0;
         pos_ff       <= '0;
         emitted_ff   <= '0;
         pc_ff        <= '0;
         accept_ff    <= V_ERR;
         time_ff      <= '0;
      end else if (fire) begin
         offset_ff    <= offset_in;
         hs_ff        <= hs_in;
         kind_ff      <= kind_in;
         pnum_ff      <= pnum_in;
         snum_ff      <= snum_in;
         expect_ff    <= expect_in;
         scan_id_ff   <= scan_id_in;
         stat_zero_ff <= stat_zero_in;
         samples_ff   <= samples_in;
         pps_ff       <= pps_in;
         step_ff      <= step_in;
         run_ff       <= run_in;
         sbytes_ff    <= sbytes_in;
         pos_ff       <= pos_in;
         emitted_ff   <= emitted_in;
         pc_ff        <= pc_in;
         accept_ff    <= accept_in;
         time_ff      <= time_in;
      end
   end

   // every final byte closes its packet with a status beat
   a_end_status: assert property (@(posedge clock) disable iff (reset)
      fire && in_item_ff.packet_end |->
         (push.num == 2'd1 && push.r0.kind == KIND_STATUS) ||
         (push.num == 2'd2 && push.r1.kind == KIND_STATUS))
      else $error("final byte without status beat");

   // a pair of beats is always a sample followed by a status
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.num == 2'd2 |-> push.r0.kind == KIND_SAMPLE && push.r1.kind == KIND_STATUS)
      else $error("bad beat pair order");

   // the offset restarts after a final byte
   a_offset_restart: assert property (@(posedge clock) disable iff (reset)
      fire && in_item_ff.packet_end |=> offset_ff == '0)
      else $error("offset did not restart");

   // nothing is pushed without room in the queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.num != 2'd0 |-> room && in_valid_ff)
      else $error("push without room");

endmodule

[rtl/scan_packet_deframer.sv]
// ---------------------------------------------------------------------------
// scan_packet_deframer: laser-scanner packet deframer
// Each accepted byte is registered in the core and decoded there; its results
// are written into the result queue, whose head entry drives the result channel.
// Throughput: one byte per cycle; a byte that completes a sample and ends
// the packet adds one beat, drained by the four-entry result queue; the
// input stalls while the queue holds more than two beats.
// Reset: synchronous, clears all packet and scan tracking, empties the queue.
// ---------------------------------------------------------------------------
module scan_packet_deframer
   import spd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   push_type push;
   logic     room;

   // decode and sample assembly
   spd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .room      (room),
      .push      (push)
   );

   // result queue
   spd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/scan_packet_deframer_test.sv]
// ---------------------------------------------------------------------------
// scan_packet_deframer_test: self-checking bench for the scan packet deframer
// Packets are built byte by byte, driven with random gaps and result stalls,
// and every result beat is checked against a cycle-free model of the
// deframer kept inside the bench.
// ---------------------------------------------------------------------------
module scan_packet_deframer_test;
   import spd_pkg::*;

   localparam int unsigned POS_LIMIT = (1 << OFFSET_BITS) - 1;

   typedef struct {
      req_type     beat;
      int unsigned gap;
   } send_item;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // byte stream waiting to be driven, results still to arrive
   send_item    byte_stream[$];
   rsp_type     deframed_results[$];
   int unsigned queued_bytes = 0;
   int unsigned bytes_accepted = 0;
   int unsigned failures = 0;
   bit          quiet_sender = 1'b0;
   bit          beat_taken = 1'b0;

   // deframer model state
   int unsigned        pos = 0;
   logic [31:0]        hdr_window = '0;
   logic [15:0]        hdr_type = '0;
   logic [15:0]        hdr_scan = '0;
   logic [15:0]        hdr_number = '0;
   logic [31:0]        hdr_status = '0;
   logic [15:0]        hdr_pps = '0;
   logic [15:0]        hdr_count = '0;
   logic [15:0]        seq_last = '0;
   logic [15:0]        scan_owner = '0;
   logic signed [31:0] angle_now = '0;
   logic signed [31:0] angle_inc = '0;
   logic [47:0]        smp_acc = '0;
   logic [2:0]         smp_fill = '0;
   logic [15:0]        smp_made = '0;
   logic [15:0]        scan_points = '0;
   logic [1:0]         pkt_verdict = V_ERR;
   logic [31:0]        pkt_stamp = '0;

   scan_packet_deframer i_dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data
   );

   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   // expected result beats join the tail of the queue
   function void expect_result(rsp_type r);
      deframed_results.insert(deframed_results.size(), r);
   endfunction

   // model: one accepted byte in, its results appended in order
   function void deframe_byte(req_type beat);
      int unsigned at;
      int unsigned smp_len;
      longint      angle_sum;
      logic [1:0]  verdict;
      rsp_type     r;
      at = pos;
      if (at == 0) begin
         pkt_stamp = beat.packet_time;
         pkt_verdict = V_ERR;
         smp_acc = '0;
         smp_fill = '0;
         smp_made = '0;
      end
      hdr_window = {beat.data_byte, hdr_window[31:8]};

      // header fields land on their last byte
      if (at < POS_LIMIT) begin
         case (at)
            OFS_TYPE:   hdr_type = hdr_window[31:16];
            OFS_SCAN:   hdr_scan = hdr_window[31:16];
            OFS_PACKET: hdr_number = hdr_window[31:16];
            OFS_STATUS: hdr_status = hdr_window;
            OFS_PPS:    hdr_pps = hdr_window[31:16];
            OFS_COUNT:  hdr_count = hdr_window[31:16];
            OFS_ANGLE:  angle_now = hdr_window;
            OFS_STEP:   angle_inc = hdr_window;
            default: ;
         endcase
         // sequence and scan check once the header is complete
         if (at == HEADER_BYTES - 1) begin
            verdict = V_ERR;
            if (hdr_number == 16'd1) begin
               seq_last = 16'd1;
               scan_owner = hdr_scan;
               scan_points = '0;
               verdict = V_OK;
            end else if (seq_last != 16'hFFFF && seq_last + 16'd1 == hdr_number) begin
               if (scan_owner != hdr_scan) begin
                  verdict = V_SCAN;
               end else begin
                  seq_last = hdr_number;
                  verdict = V_OK;
               end
            end
            if (verdict == V_OK && hdr_status == '0 && hdr_type != TYPE_A
                && hdr_type != TYPE_B)
               verdict = V_ERR;
            pkt_verdict = verdict;
         end
      end

      // sample assembly after the header
      if (at >= HEADER_BYTES && pkt_verdict == V_OK && hdr_status == '0
          && (hdr_type == TYPE_A || hdr_type == TYPE_B) && smp_made < hdr_count) begin
         smp_len = (hdr_type == TYPE_B) ? 32'(SIZE_B) : 32'(SIZE_A);
         smp_acc[8*smp_fill +: 8] = beat.data_byte;
         smp_fill++;
         if (smp_fill >= smp_len) begin
            r = '0;
            r.kind = KIND_SAMPLE;
            r.distance = smp_acc[31:0];
            r.amplitude = (hdr_type == TYPE_B) ? smp_acc[47:32] : 16'd0;
            r.angle = angle_now;
            angle_sum = longint'(angle_now) + longint'(angle_inc);
            if (angle_sum > 64'sd2147483647)
               angle_now = 32'sh7FFF_FFFF;
            else if (angle_sum < -64'sd2147483648)
               angle_now = 32'sh8000_0000;
            else
               angle_now = 32'(angle_sum);
            smp_made++;
            if (scan_points != 16'hFFFF)
               scan_points++;
            r.sample_time = pkt_stamp;
            r.verdict = V_OK;
            r.points_collected = scan_points;
            r.last = !beat.packet_end;
            smp_acc = '0;
            smp_fill = '0;
            expect_result(r);
         end
      end

      // status beat closes every packet
      if (beat.packet_end) begin
         verdict = V_ERR;
         if (at >= HEADER_BYTES || (at == HEADER_BYTES - 1 && at < POS_LIMIT)) begin
            verdict = pkt_verdict;
            if (hdr_pps == '0)
               verdict = V_ERR;
            else if (hdr_pps == scan_points)
               verdict = V_DONE;
         end
         r = '0;
         r.kind = KIND_STATUS;
         r.sample_time = pkt_stamp;
         r.verdict = verdict;
         r.points_collected = scan_points;
         r.last = 1'b1;
         expect_result(r);
         pos = 0;
      end else if (at < POS_LIMIT) begin
         pos = at + 1;
      end
   endfunction

   function string show_result(rsp_type r);
      return $sformatf("kind %0d dist %h amp %h angle %0d time %h verdict %0d points %0d last %0d",
                       r.kind, r.distance, r.amplitude, r.angle, r.sample_time, r.verdict,
                       r.points_collected, r.last);
   endfunction

   task note_failure(string what);
      failures++;
      if (failures <= 10)
         $display("%s", what);
   endtask

   // mostly short gaps, a few long ones, none while the sender is quiet
   function int unsigned sender_gap();
      int unsigned draw;
      draw = $urandom_range(0, 99);
      if (quiet_sender || draw < 65)
         return 0;
      if (draw < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one packet: header fields placed little-endian over random filler
   task automatic send_packet(input logic [15:0] code, scan, number,
                              input logic [31:0] status,
                              input logic [15:0] pps, count,
                              input logic [31:0] first_angle, angle_step,
                              input int unsigned len, input int fill);
      logic [7:0] hdr [HEADER_BYTES];
      send_item   item;
      for (int i = 0; i < HEADER_BYTES; i++)
         hdr[i] = 8'($urandom);
      for (int k = 0; k < 2; k++) begin
         hdr[OFS_TYPE - 1 + k] = code[8*k +: 8];
         hdr[OFS_SCAN - 1 + k] = scan[8*k +: 8];
         hdr[OFS_PACKET - 1 + k] = number[8*k +: 8];
         hdr[OFS_PPS - 1 + k] = pps[8*k +: 8];
         hdr[OFS_COUNT - 1 + k] = count[8*k +: 8];
      end
      for (int k = 0; k < 4; k++) begin
         hdr[OFS_STATUS - 3 + k] = status[8*k +: 8];
         hdr[OFS_ANGLE - 3 + k] = first_angle[8*k +: 8];
         hdr[OFS_STEP - 3 + k] = angle_step[8*k +: 8];
      end
      for (int unsigned i = 0; i < len; i++) begin
         if (i < HEADER_BYTES)
            item.beat.data_byte = hdr[i];
         else if (fill < 0)
            item.beat.data_byte = 8'($urandom);
         else
            item.beat.data_byte = 8'(fill);
         item.beat.packet_end = (i == len - 1);
         item.beat.packet_time = $urandom;
         item.gap = sender_gap();
         byte_stream.insert(byte_stream.size(), item);
         queued_bytes++;
      end
   endtask

   // byte driver, changes on the falling edge
   send_item    next_item;
   bit          have_next = 1'b0;
   int unsigned gap_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || beat_taken) begin
         if (!have_next && byte_stream.size() > 0) begin
            next_item = byte_stream.pop_front();
            have_next = 1'b1;
            gap_left = next_item.gap;
         end
         if (have_next && gap_left == 0) begin
            req_valid <= 1'b1;
            req_data <= next_item.beat;
            have_next = 1'b0;
         end else begin
            req_valid <= 1'b0;
            if (gap_left > 0)
               gap_left--;
         end
      end
   end

   // result stall pattern, with calm stretches between busy ones
   int unsigned stall_hold = 0;
   int unsigned phase_left = 0;
   bit          calm_phase = 1'b0;
   int unsigned stall_draw;

   always @(negedge clock) begin
      if (phase_left == 0) begin
         calm_phase = ($urandom_range(0, 3) == 0);
         phase_left = $urandom_range(20, 200);
      end else begin
         phase_left--;
      end
      if (stall_hold > 0) begin
         stall_hold--;
      end else begin
         stall_draw = $urandom_range(0, 99);
         if (calm_phase || stall_draw < 80) begin
            rsp_stall <= 1'b0;
         end else if (stall_draw < 98) begin
            rsp_stall <= 1'b1;
            stall_hold = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_hold = $urandom_range(10, 30);
         end
      end
   end

   // monitor: predict on accepted bytes, check result beats in order
   rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         beat_taken = 1'b0;
      end else begin
         beat_taken = req_valid && !req_stall;
         if (beat_taken) begin
            deframe_byte(req_data);
            bytes_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (deframed_results.size() == 0) begin
               note_failure($sformatf("unexpected result beat: %s", show_result(rsp_data)));
            end else begin
               want = deframed_results.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.distance !== want.distance
                   || rsp_data.amplitude !== want.amplitude || rsp_data.angle !== want.angle
                   || rsp_data.sample_time !== want.sample_time
                   || rsp_data.verdict !== want.verdict
                   || rsp_data.points_collected !== want.points_collected
                   || rsp_data.last !== want.last)
                  note_failure($sformatf("result mismatch\n  expected %s\n  actual   %s",
                                         show_result(want), show_result(rsp_data)));
            end
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int unsigned pick;
      int unsigned shape;
      int unsigned count;
      int unsigned size;
      int unsigned len;
      int unsigned target;
      logic [15:0] code;
      logic [15:0] scan_no;
      logic [15:0] next_no;
      logic [15:0] number;
      logic [15:0] scan;
      logic [15:0] scan_pps;
      logic [15:0] gathered;
      logic [31:0] status;
      logic [31:0] first_angle;
      logic [31:0] angle_step;
      bit          scan_open;

      // lone end byte, then a header one byte short
      send_packet(TYPE_A, 16'd7, 16'd1, '0, 16'd6, 16'd3, '0, 32'd1000, 1, -1);
      send_packet(TYPE_A, 16'd7, 16'd1, '0, 16'd6, 16'd3, '0, 32'd1000, HEADER_BYTES - 1, -1);
      // scan start with all-ones samples, type B follow-up with all-zero ones
      send_packet(TYPE_A, 16'd7, 16'd1, '0, 16'd6, 16'd3, '0, 32'd1000, HEADER_BYTES + 12, 255);
      send_packet(TYPE_B, 16'd7, 16'd2, '0, 16'd6, 16'd3, 32'd3000, -32'sd500,
                  HEADER_BYTES + 18, 0);
      // right number, wrong scan
      send_packet(TYPE_A, 16'd8, 16'd3, '0, 16'd5, 16'd2, '0, 32'd1, HEADER_BYTES + 8, -1);
      // device status set: accepted but silent
      send_packet(TYPE_B, 16'd7, 16'd3, 32'h8000_0001, 16'd9, 16'd2, '0, 32'd1,
                  HEADER_BYTES + 12, -1);
      // unknown type, then a number out of sequence
      send_packet(16'h1234, 16'd7, 16'd4, '0, 16'd9, 16'd2, '0, 32'd1, HEADER_BYTES + 8, -1);
      send_packet(TYPE_A, 16'd7, 16'd9, '0, 16'd9, 16'd2, '0, 32'd1, HEADER_BYTES + 8, -1);
      // header only, ending on its last byte
      send_packet(TYPE_A, 16'd7, 16'd5, '0, 16'd9, 16'd2, '0, 32'd1, HEADER_BYTES, -1);
      // zero points per scan
      send_packet(TYPE_A, 16'hFFFF, 16'd1, '0, '0, 16'd2, '0, 32'd7, HEADER_BYTES + 8, -1);
      // trailing partial sample, then surplus bytes past the count
      send_packet(TYPE_A, 16'hFFFF, 16'd2, '0, 16'hFFFF, 16'd4, '0, 32'd7, HEADER_BYTES + 6, -1);
      send_packet(TYPE_B, 16'hFFFF, 16'd3, '0, 16'hFFFF, 16'd2, '0, 32'd7, HEADER_BYTES + 16, -1);
      // angle clamps at the top, then at the bottom
      send_packet(TYPE_A, '0, 16'd1, '0, 16'd3, 16'd3, 32'h7FFF_F000, 32'h1000_0000,
                  HEADER_BYTES + 12, -1);
      send_packet(TYPE_A, '0, 16'd2, '0, 16'd6, 16'd3, 32'h8000_1000, 32'h9000_0000,
                  HEADER_BYTES + 12, -1);

      // random traffic, mostly well-formed scans
      scan_open = 1'b0;
      scan_no = '0;
      next_no = '0;
      scan_pps = '0;
      gathered = '0;
      target = 1300;
      while (queued_bytes < target) begin
         quiet_sender = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send_packet(16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                        16'($urandom), 16'($urandom), $urandom, $urandom,
                        $urandom_range(1, 130), -1);
         end else begin
            if (!scan_open || $urandom_range(0, 7) == 0) begin
               scan_open = 1'b1;
               scan_no = 16'($urandom);
               next_no = 16'd1;
               gathered = '0;
               scan_pps = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 40));
            end
            code = $urandom_range(0, 1) ? TYPE_B : TYPE_A;
            if ($urandom_range(0, 19) == 0)
               code = 16'($urandom);
            status = ($urandom_range(0, 9) == 0) ? $urandom : 32'd0;
            count = $urandom_range(0, 10);
            if (scan_pps > gathered && scan_pps - gathered <= 10 && $urandom_range(0, 1))
               count = 32'(scan_pps - gathered);
            size = (code == TYPE_B) ? 32'(SIZE_B) : 32'(SIZE_A);
            len = HEADER_BYTES + count * size;
            shape = $urandom_range(0, 9);
            if (shape == 0)
               len = len + $urandom_range(1, 8);
            else if (shape == 1 && count > 0)
               len = len - $urandom_range(1, size);
            else if (shape == 2)
               len = $urandom_range(1, HEADER_BYTES);
            first_angle = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3600000);
            angle_step = ($urandom_range(0, 9) == 0) ? $urandom
                                                       : 32'($urandom_range(0, 20000)) - 32'd10000;
            number = next_no;
            scan = scan_no;
            // broken sequence: stray number or foreign scan
            if (pick < 15) begin
               if ($urandom_range(0, 1))
                  number = 16'($urandom);
               else
                  scan = 16'($urandom);
            end
            send_packet(code, scan, number, status, scan_pps, 16'(count), first_angle,
                        angle_step, len, -1);
            if (pick >= 15 && len >= HEADER_BYTES) begin
               next_no++;
               gathered += 16'(count);
            end
         end
      end
      quiet_sender = 1'b0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (bytes_accepted == queued_bytes);
      while (deframed_results.size() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);

      if (failures == 0 && deframed_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
